### rtl/core/hdiq_pkg.sv
// hdiq_pkg: shared types, constants and constant tables for the directed indel quality core
// holds the error term rom, the quality threshold tables and the closed-run record type
// no dependencies
package hdiq_pkg;

   // longest run before it is split
   localparam logic [7:0] MAX_RUN = 8'd255;

   // closed-run queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // quality search ranges
   localparam int POS_STEPS = 96;
   localparam int NEG_STEPS = 24;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAP_LIMIT          = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELETION_DIRECTION = 1'b1;

   localparam logic [7:0]  CAP_LIMIT_RESET = 8'd40;
   localparam logic        DIRECTION_RESET = 1'b1;

   // U8.32 value of 1.0
   localparam logic [39:0] SUM_ONE = 40'h01_0000_0000;

   typedef struct packed {
      logic [39:0] sum;
      logic [7:0]  len;
      logic        last;
   } run_rec_type;

   typedef struct packed {
      logic        push_a;
      logic        push_b;
      run_rec_type rec_a;
      run_rec_type rec_b;
   } run_close_type;

   typedef logic [32:0] term_rom_type [128];
   typedef logic [39:0] pos_thr_type [POS_STEPS];
   typedef logic [39:0] neg_thr_type [NEG_STEPS];

   localparam logic [63:0] TEN16 = 64'd10000000000000000;

   // 10^(-k/10) scaled by 10^16, k = 0..9
   localparam logic [63:0] ROOT_TAB [10] = '{
      64'd10000000000000000, 64'd7943282347242815, 64'd6309573444801932,
      64'd5011872336272723,  64'd3981071705534973, 64'd3162277660168379,
      64'd2511886431509580,  64'd1995262314968880, 64'd1584893192461113,
      64'd1258925411794167
   };

   // floor(2^sh * 10^(-m/10)) for m in -30..127, bit 64 flags a dropped remainder
   function automatic logic [64:0] pow_floor(input int m, input int sh);
      int          t;
      int          a;
      int          i;
      logic [63:0] num;
      logic [63:0] q;
      logic [63:0] r;
      logic        ix;
      t   = m + 30;
      a   = (t / 10) - 3;
      num = ROOT_TAB[t % 10];
      for (i = a; i < 0; i++) begin
         num = num * 64'd10;
      end
      q = num / TEN16;
      r = num % TEN16;
      for (i = 0; i < sh; i++) begin
         q = q << 1;
         r = r << 1;
         if (r >= TEN16) begin
            r    = r - TEN16;
            q[0] = 1'b1;
         end
      end
      ix = (r != 64'd0);
      for (i = 0; i < a; i++) begin
         if ((q % 64'd10) != 64'd0) begin
            ix = 1'b1;
         end
         q = q / 64'd10;
      end
      return {ix, q};
   endfunction

   // rounded U1.32 error term per phred quality, entry 0 is exactly 1.0
   function automatic term_rom_type build_term_rom();
      term_rom_type rom;
      logic [64:0]  pf;
      int           q;
      for (q = 0; q < 128; q++) begin
         pf     = pow_floor(q, 33);
         rom[q] = 33'((pf[63:0] + 64'd1) >> 1);
      end
      return rom;
   endfunction

   // entry i: largest sum that still earns quality i+1
   function automatic pos_thr_type build_pos_thr();
      pos_thr_type thr;
      logic [64:0] pf;
      int          i;
      for (i = 0; i < POS_STEPS; i++) begin
         pf     = pow_floor(i + 1, 32);
         thr[i] = pf[39:0];
      end
      return thr;
   endfunction

   // entry i: smallest sum that earns quality -(i+1)
   function automatic neg_thr_type build_neg_thr();
      neg_thr_type thr;
      logic [64:0] pf;
      int          i;
      for (i = 0; i < NEG_STEPS; i++) begin
         pf     = pow_floor(-(i + 1), 32);
         thr[i] = pf[39:0] + {39'd0, pf[64]};
      end
      return thr;
   endfunction

   localparam term_rom_type TERM_ROM = build_term_rom();
   localparam pos_thr_type  POS_THR  = build_pos_thr();
   localparam neg_thr_type  NEG_THR  = build_neg_thr();

endpackage

### rtl/core/homopolymer_directed_indel_quality_core.sv
// homopolymer_directed_indel_quality_core: top level of the directed indel quality block
// ties together run tracking, the closed-run queue and the quality pipeline
// depends on hdiq_pkg, hdiq_run, hdiq_queue, hdiq_qual
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata: base, base_quality, indel_offset; tlast
//   rsp      out        rsp_tvalid/rsp_tready  tdata: directed_quality, run_length; tlast
//   csr      in         csr_we                 csr_index, csr_wdata
//
// one base is taken per cycle while the queue has room for two; a base closes at most two
// runs (the open run on a base change or length limit, and its own run at end of read);
// results leave one per cycle while rsp_tready is high, so a stream of two-result bases
// is paced by the rsp port
// synchronous reset clears run state, queue pointers and all valid flags; config resets
// to cap 40 and deletion direction
// a stalled rsp fills the pipeline, then the queue, then the input register, after
// which req_tready drops
module homopolymer_directed_indel_quality_core
   import hdiq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [23:0]            req_tdata,   // base[7:0], base_quality[14:8], indel_offset[22:15], zero pad
   input  logic                   req_tlast,   // end_of_read
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tdata,   // directed_quality[7:0], run_length[15:8]
   output logic                   rsp_tlast,   // last_of_read
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [6:0]             csr_wdata
);

   // configuration registers
   logic [6:0] cap_ff;
   logic       dir_ff;

   // run tracker to queue
   run_close_type close;
   logic          space_ok;

   // queue to quality pipeline
   logic        q_valid;
   logic        q_ready;
   run_rec_type q_rec;

   logic [7:0] rsp_quality;
   logic [7:0] rsp_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_LIMIT_RESET[6:0];
         dir_ff <= DIRECTION_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CAP_LIMIT: begin
               cap_ff <= csr_wdata;
            end
            CSR_DELETION_DIRECTION: begin
               dir_ff <= csr_wdata[0];
            end
         endcase
      end
   end

   // input register, rom lookup and run accumulate
   hdiq_run u_run (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_base    (req_tdata[7:0]),
      .in_quality (req_tdata[14:8]),
      .in_tp      (req_tdata[22:15]),
      .in_end     (req_tlast),
      .direction  (dir_ff),
      .space_ok   (space_ok),
      .close      (close)
   );

   // closed runs wait here, room for two is needed before a base moves on
   hdiq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .close     (close),
      .space_ok  (space_ok),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_rec   (q_rec)
   );

   // log quality by threshold compares, ends in the result register
   hdiq_qual u_qual (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_valid),
      .in_ready    (q_ready),
      .in_rec      (q_rec),
      .cap_limit   (cap_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_quality (rsp_quality),
      .out_len     (rsp_len),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {rsp_len, rsp_quality};

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // every reported run holds at least one base
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:8] != 8'd0))
      else $error("zero run length reported");

   // the sum of at most the length limit of terms stays at or above the lowest quality, -24
   a_quality_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[7:0]) >= -8'sd24))
      else $error("quality below the lowest reachable value");

   // the run tracker only closes runs when the queue has room for two
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      (close.push_a || close.push_b) |-> space_ok)
      else $error("closed run pushed without queue room");

endmodule

### rtl/core/hdiq_run.sv
// hdiq_run: input register, error term lookup and homopolymer run tracking
// closes runs on base change, length limit and end of read, up to two per base
// depends on hdiq_pkg
module hdiq_run
   import hdiq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [7:0]    in_base,
   input  logic [6:0]    in_quality,
   input  logic [7:0]    in_tp,
   input  logic          in_end,
   input  logic          direction,
   input  logic          space_ok,
   output run_close_type close
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_base_ff;
   logic [32:0] in_term_ff, term_in;
   logic        in_end_ff;

   logic [7:0]  run_base_ff, run_base_in;
   logic [7:0]  run_count_ff, run_count_in;
   logic [39:0] run_sum_ff, run_sum_in;

   logic        advance;
   logic        load;
   logic        close_old;
   logic [7:0]  cnt0, cnt1;
   logic [39:0] sum0, sum1;

   assign advance  = in_valid_ff && space_ok;
   assign in_ready = !in_valid_ff || advance;
   assign load     = in_valid && in_ready;

   // term counts only for a nonzero offset pointing the chosen way
   always_comb begin
      if ((in_tp != 8'd0) && (in_tp[7] == direction)) begin
         term_in = TERM_ROM[in_quality];
      end else begin
         term_in = '0;
      end
   end

   always_comb begin
      close_old = (run_count_ff != 8'd0) &&
                  ((in_base_ff != run_base_ff) || (run_count_ff >= MAX_RUN));
      cnt0 = close_old ? 8'd0  : run_count_ff;
      sum0 = close_old ? 40'd0 : run_sum_ff;
      cnt1 = cnt0 + 8'd1;
      sum1 = sum0 + {7'd0, in_term_ff};

      close.push_a = advance && close_old;
      close.rec_a  = '{sum: run_sum_ff, len: run_count_ff, last: 1'b0};
      close.push_b = advance && in_end_ff;
      close.rec_b  = '{sum: sum1, len: cnt1, last: 1'b1};

      in_valid_in  = load || (in_valid_ff && !advance);
      run_base_in  = run_base_ff;
      run_count_in = run_count_ff;
      run_sum_in   = run_sum_ff;
      if (advance) begin
         if (cnt0 == 8'd0) begin
            run_base_in = in_base_ff;
         end
         if (in_end_ff) begin
            run_count_in = 8'd0;
            run_sum_in   = 40'd0;
         end else begin
            run_count_in = cnt1;
            run_sum_in   = sum1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         run_base_ff  <= 8'd0;
         run_count_ff <= 8'd0;
         run_sum_ff   <= 40'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         run_base_ff  <= run_base_in;
         run_count_ff <= run_count_in;
         run_sum_ff   <= run_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_base_ff <= in_base;
         in_term_ff <= term_in;
         in_end_ff  <= in_end;
      end
   end

endmodule

### rtl/core/hdiq_queue.sv
// hdiq_queue: small queue of closed runs, two writes and one read per cycle
// decouples run tracking from the quality pipeline
// depends on hdiq_pkg
module hdiq_queue
   import hdiq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  run_close_type close,
   output logic          space_ok,
   output logic          out_valid,
   input  logic          out_ready,
   output run_rec_type   out_rec
);

   run_rec_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wp_ff, wp_in;
   logic [QPTR_W-1:0] rp_ff, rp_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QPTR_W-1:0] wp_b;
   logic              pop;

   assign space_ok  = count_ff <= QCNT_W'(QUEUE_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_rec   = mem_ff[rp_ff];
   assign pop       = out_valid && out_ready;
   assign wp_b      = wp_ff + QPTR_W'(close.push_a);

   always_comb begin
      wp_in    = wp_ff + QPTR_W'(close.push_a) + QPTR_W'(close.push_b);
      rp_in    = rp_ff + QPTR_W'(pop);
      count_in = count_ff + QCNT_W'(close.push_a) + QCNT_W'(close.push_b) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (close.push_a) begin
         mem_ff[wp_ff] <= close.rec_a;
      end
      if (close.push_b) begin
         mem_ff[wp_b] <= close.rec_b;
      end
   end

endmodule

### rtl/core/hdiq_qual.sv
// hdiq_qual: error sum to phred quality, threshold compares then one-hot encode
// three stallable stages, the last one is the result register
// depends on hdiq_pkg
module hdiq_qual
   import hdiq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  run_rec_type in_rec,
   input  logic [6:0]  cap_limit,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [7:0]  out_quality,
   output logic [7:0]  out_len,
   output logic        out_last
);

   logic        s1_valid_ff;
   run_rec_type s1_rec_ff;

   logic                 s2_valid_ff;
   logic                 s2_zero_ff, s2_big_ff;
   logic [POS_STEPS-1:0] s2_pos_ff, pos_in;
   logic [NEG_STEPS-1:0] s2_neg_ff, neg_in;
   logic [7:0]           s2_len_ff;
   logic                 s2_last_ff;

   logic       out_valid_ff;
   logic [7:0] out_quality_ff, quality_in;
   logic [7:0] out_len_ff;
   logic       out_last_ff;

   logic out_en, s2_en, s1_en;

   logic [POS_STEPS-1:0] pos_hit;
   logic [NEG_STEPS-1:0] neg_hit;
   logic [6:0]           qpos;
   logic [4:0]           qneg;

   assign out_en   = !out_valid_ff || out_ready;
   assign s2_en    = !s2_valid_ff || out_en;
   assign s1_en    = !s1_valid_ff || s2_en;
   assign in_ready = s1_en;

   // thresholds are monotonic, so each compare vector is a thermometer
   always_comb begin
      for (int i = 0; i < POS_STEPS; i++) begin
         pos_in[i] = s1_rec_ff.sum <= POS_THR[i];
      end
      for (int i = 0; i < NEG_STEPS; i++) begin
         neg_in[i] = s1_rec_ff.sum >= NEG_THR[i];
      end
   end

   // top of each thermometer
   always_comb begin
      pos_hit = s2_pos_ff & ~{1'b0, s2_pos_ff[POS_STEPS-1:1]};
      neg_hit = s2_neg_ff & ~{1'b0, s2_neg_ff[NEG_STEPS-1:1]};
      qpos    = '0;
      qneg    = '0;
      for (int i = 0; i < POS_STEPS; i++) begin
         if (pos_hit[i]) begin
            qpos = qpos | 7'(i + 1);
         end
      end
      for (int i = 0; i < NEG_STEPS; i++) begin
         if (neg_hit[i]) begin
            qneg = qneg | 5'(i + 1);
         end
      end
      priority if (s2_zero_ff) begin
         quality_in = {1'b0, cap_limit};
      end else if (s2_big_ff) begin
         quality_in = 8'd0 - {3'd0, qneg};
      end else if (qpos > cap_limit) begin
         quality_in = {1'b0, cap_limit};
      end else begin
         quality_in = {1'b0, qpos};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_en) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_rec_ff <= in_rec;
      end
      if (s2_en) begin
         s2_zero_ff <= s1_rec_ff.sum == 40'd0;
         s2_big_ff  <= s1_rec_ff.sum > SUM_ONE;
         s2_pos_ff  <= pos_in;
         s2_neg_ff  <= neg_in;
         s2_len_ff  <= s1_rec_ff.len;
         s2_last_ff <= s1_rec_ff.last;
      end
      if (out_en) begin
         out_quality_ff <= quality_in;
         out_len_ff     <= s2_len_ff;
         out_last_ff    <= s2_last_ff;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_quality = out_quality_ff;
   assign out_len     = out_len_ff;
   assign out_last    = out_last_ff;

endmodule

### sim/tb.sv
// tb: self-checking bench for homopolymer_directed_indel_quality_core
// streams reads as run-structured base sequences and checks every run quality it reports
// depends on hdiq_pkg and the core rtl
module tb;
   import hdiq_pkg::*;

   // expected run result, fields as they leave on the rsp channel
   typedef struct packed {
      logic [7:0] quality;
      logic [7:0] len;
      logic       last;
   } run_result_type;

   // tracks open run and error sum, predicts one record per closed run
   class run_quality_scoreboard;
      logic [63:0] deci_root [10];
      logic [32:0] err_term [128];
      logic [39:0] pos_limit [1:96];
      logic [39:0] neg_limit [1:24];
      logic [6:0]  cap;
      logic        del_dir;
      logic [7:0]  run_base;
      logic [7:0]  run_len;
      logic [39:0] run_sum;
      run_result_type expected_runs[$];
      int          fail_count;
      int          result_count;

      // floor(2^sh * 10^(-m/10)) by one wide division; inexact set on a remainder
      function logic [127:0] scaled_power(input int m, input int sh, output bit inexact);
         int           t;
         int           a;
         int           i;
         logic [127:0] num;
         logic [127:0] den;
         t   = m + 30;
         a   = t / 10 - 3;
         num = 128'(deci_root[t % 10]);
         den = 128'd10000000000000000;
         for (i = a; i < 0; i++) num = num * 128'd10;
         for (i = 0; i < a; i++) den = den * 128'd10;
         num     = num << sh;
         inexact = (num % den) != 128'd0;
         return num / den;
      endfunction

      function new();
         bit           ix;
         logic [127:0] v;
         int           k;
         deci_root = '{64'd10000000000000000, 64'd7943282347242815, 64'd6309573444801932,
                       64'd5011872336272723,  64'd3981071705534973, 64'd3162277660168379,
                       64'd2511886431509580,  64'd1995262314968880, 64'd1584893192461113,
                       64'd1258925411794167};
         // rounded U1.32 error terms, quality 0 gives exactly 1.0
         for (k = 0; k < 128; k++) begin
            v           = scaled_power(k, 33, ix);
            err_term[k] = 33'((v + 128'd1) >> 1);
         end
         // largest sum still earning quality k
         for (k = 1; k <= 96; k++) begin
            v            = scaled_power(k, 32, ix);
            pos_limit[k] = v[39:0];
         end
         // smallest sum earning quality -k
         for (k = 1; k <= 24; k++) begin
            v = scaled_power(-k, 32, ix);
            if (ix) v = v + 128'd1;
            neg_limit[k] = v[39:0];
         end
         cap          = CAP_LIMIT_RESET[6:0];
         del_dir      = DIRECTION_RESET;
         run_base     = '0;
         run_len      = '0;
         run_sum      = '0;
         fail_count   = 0;
         result_count = 0;
      endfunction

      function void set_register(input logic [CSR_INDEX_W-1:0] idx, input logic [6:0] val);
         if (idx == CSR_CAP_LIMIT) cap = val;
         else if (idx == CSR_DELETION_DIRECTION) del_dir = val[0];
      endfunction

      function logic [7:0] directed_quality_of_run();
         int q;
         int k;
         q = 0;
         if (run_sum == 40'd0) return {1'b0, cap};
         if (run_sum <= SUM_ONE) begin
            for (k = 1; k <= 96; k++) if (run_sum <= pos_limit[k]) q = k;
         end else begin
            for (k = 1; k <= 24; k++) if (run_sum >= neg_limit[k]) q = -k;
         end
         if (q > int'(cap)) q = int'(cap);
         return 8'(q);
      endfunction

      function void close_run(input logic last);
         run_result_type r;
         r.quality = directed_quality_of_run();
         r.len     = run_len;
         r.last    = last;
         expected_runs.push_back(r);
         run_len = '0;
         run_sum = '0;
      endfunction

      // one accepted base
      function void note_base(input logic [7:0] b, input logic [6:0] q,
                              input logic [7:0] tp, input logic eor);
         if (run_len != 8'd0 && (b != run_base || run_len >= MAX_RUN)) close_run(1'b0);
         if (run_len == 8'd0) run_base = b;
         run_len = run_len + 8'd1;
         if (tp != 8'd0 && tp[7] == del_dir) run_sum = run_sum + 40'(err_term[q]);
         if (eor) close_run(1'b1);
      endfunction

      function void check_run_result(input logic [7:0] q, input logic [7:0] len,
                                     input logic last);
         run_result_type e;
         result_count++;
         if (expected_runs.size() == 0) begin
            $error("run result with none expected: quality %0d length %0d last %0b",
                   $signed(q), len, last);
            fail_count++;
            return;
         end
         e = expected_runs.pop_front();
         if (q !== e.quality) begin
            $error("directed_quality: expected %0d, got %0d", $signed(e.quality), $signed(q));
            fail_count++;
         end
         if (len !== e.len) begin
            $error("run_length: expected %0d, got %0d", e.len, len);
            fail_count++;
         end
         if (last !== e.last) begin
            $error("last_of_read: expected %0b, got %0b", e.last, last);
            fail_count++;
         end
      endfunction

      function int pending();
         return expected_runs.size();
      endfunction
   endclass

   // cycles allowed after the last expected result, as a margin over the pipeline
   localparam int SETTLE_CYCLES    = 20;
   localparam int PHASES           = 6;
   localparam int RANDOM_PER_PHASE = 128;
   // one run past the length limit, split into a full run and a short one
   localparam int LONG_RUN_LEN     = 257;

   localparam logic [7:0] NUCLEOTIDE [4] = '{8'h41, 8'h43, 8'h47, 8'h54};

   // register settings per phase; phase 0 keeps the reset values
   localparam logic [6:0] PHASE_CAP [PHASES] = '{7'd40, 7'd93, 7'd0, 7'd127, 7'd96, 7'd25};
   localparam logic       PHASE_DIR [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

   // directed bases, packed {end_of_read, indel_offset, base_quality, base}
   localparam logic [23:0] OPENING_BASES [17] = '{
      {1'b1, 8'hff, 7'd0,   8'h41},   // sum exactly 1.0, quality 0
      {1'b1, 8'h80, 7'd93,  8'h00},   // tiny term, clamped to cap
      {1'b1, 8'hff, 7'd127, 8'hff},   // zero term, empty sum gives cap
      {1'b0, 8'h7f, 7'd20,  8'h43},   // wrong direction, ignored
      {1'b0, 8'hfb, 7'd10,  8'h43},
      {1'b0, 8'h00, 7'd30,  8'h47},   // no offset, ignored
      {1'b0, 8'hff, 7'd30,  8'h47},
      {1'b1, 8'h01, 7'd3,   8'h54},
      {1'b0, 8'hff, 7'd0,   8'h41},   // sum above 1.0, negative quality
      {1'b0, 8'hff, 7'd0,   8'h41},
      {1'b0, 8'hff, 7'd0,   8'h41},
      {1'b1, 8'hfe, 7'd0,   8'h41},
      {1'b0, 8'hff, 7'd5,   8'h43},
      {1'b1, 8'h81, 7'd5,   8'h54},   // base change and end of read in one transfer
      {1'b0, 8'h01, 7'd0,   8'haa},
      {1'b0, 8'h00, 7'd0,   8'h55},
      {1'b1, 8'h7f, 7'd127, 8'h80}
   };

   // reads with cap 127 and insertion direction: several results above 93
   localparam logic [23:0] HIGH_CAP_BASES [6] = '{
      {1'b1, 8'h01, 7'd96,  8'h01},
      {1'b1, 8'h7f, 7'd99,  8'h02},
      {1'b1, 8'h01, 7'd100, 8'h03},
      {1'b1, 8'h01, 7'd50,  8'h04},
      {1'b0, 8'h01, 7'd0,   8'h05},
      {1'b1, 8'h01, 7'd0,   8'h05}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [23:0]            req_tdata;   // base[7:0], base_quality[14:8], indel_offset[22:15], pad
   logic                   req_tlast;   // end_of_read
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [15:0]            rsp_tdata;   // directed_quality[7:0], run_length[15:8]
   logic                   rsp_tlast;   // last_of_read
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [6:0]             csr_wdata;

   run_quality_scoreboard sb;

   // pacing knobs, set per phase
   bit req_steady;
   bit rsp_steady;
   int burst_left;
   int base_count;
   int phase_items;

   homopolymer_directed_indel_quality_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one base transfer, with a random gap whenever a burst runs out and req pacing is not steady
   task automatic send_base(input logic [7:0] b, input logic [6:0] q,
                            input logic [7:0] tp, input logic eor);
      int gap;
      if (!req_steady && burst_left <= 0) begin
         gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, tp, q, b};
      req_tlast  <= eor;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_base(b, q, tp, eor);
      base_count++;
      phase_items++;
   endtask

   // both registers on consecutive edges, write enable held high between them
   task automatic apply_settings(input logic [6:0] cap, input logic dir);
      csr_we    <= 1'b1;
      csr_index <= CSR_CAP_LIMIT;
      csr_wdata <= cap;
      @(posedge clock);
      sb.set_register(CSR_CAP_LIMIT, cap);
      csr_index <= CSR_DELETION_DIRECTION;
      csr_wdata <= {6'd0, dir};
      @(posedge clock);
      sb.set_register(CSR_DELETION_DIRECTION, {6'd0, dir});
      csr_we <= 1'b0;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one read: mostly well-formed runs, some reads pure noise; never past the phase budget
   task automatic send_read();
      int         nruns;
      int         r;
      int         i;
      int         len;
      int         rem;
      bit         dense;
      logic [7:0] b;
      logic [7:0] prev_b;
      logic [7:0] tp;
      logic [6:0] q;
      if ($urandom_range(0, 11) == 0) begin
         len = $urandom_range(1, 12);
         if (len > RANDOM_PER_PHASE - phase_items) len = RANDOM_PER_PHASE - phase_items;
         for (i = 0; i < len; i++)
            send_base(8'($urandom), 7'($urandom), 8'($urandom),
                      (i == len - 1) || ($urandom_range(0, 4) == 0));
         return;
      end
      nruns  = $urandom_range(1, 6);
      prev_b = 8'($urandom);
      for (r = 0; r < nruns; r++) begin
         // a repeated base just merges into the previous run
         do begin
            b = ($urandom_range(0, 3) != 0) ? NUCLEOTIDE[$urandom_range(0, 3)] : 8'($urandom);
         end while (b == prev_b && $urandom_range(0, 9) != 0);
         prev_b = b;
         case ($urandom_range(0, 49))
            0, 1:    len = $urandom_range(40, 120);   // long run
            default: len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 40)
                                                        : $urandom_range(1, 6);
         endcase
         // a run that reaches the budget is cut there and closes the read
         rem = RANDOM_PER_PHASE - phase_items;
         if (len >= rem) begin
            len   = rem;
            nruns = r + 1;
         end
         // dense runs carry heavy errors in the counted direction
         dense = ($urandom_range(0, 3) == 0) || (len > 60 && $urandom_range(0, 1) == 0);
         for (i = 0; i < len; i++) begin
            if (dense) begin
               q  = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(0, 3));
               tp = sb.del_dir ? 8'(-$urandom_range(1, 3)) : 8'($urandom_range(1, 3));
            end else begin
               case ($urandom_range(0, 9))
                  0, 1:    q = 7'($urandom_range(46, 93));
                  2:       q = 7'($urandom_range(94, 127));
                  default: q = 7'($urandom_range(0, 45));
               endcase
               case ($urandom_range(0, 9))
                  0, 1, 2: tp = 8'h00;
                  3:       tp = ($urandom_range(0, 1) == 0) ? 8'h80 : 8'h7f;
                  default: tp = 8'($urandom);
               endcase
            end
            send_base(b, q, tp, (r == nruns - 1) && (i == len - 1));
         end
      end
   endtask

   // receiver: alternating ready and stall stretches, or always ready
   initial begin : rsp_side
      int hold;
      bit rdy;
      hold = 0;
      rdy  = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_run_result(rsp_tdata[7:0], rsp_tdata[15:8], rsp_tlast);
         if (rsp_steady) begin
            rdy  = 1'b1;
            hold = 0;
         end else if (hold <= 0) begin
            rdy = !rdy;
            if (rdy) hold = $urandom_range(1, 24);
            else hold = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 30)
                                                    : $urandom_range(1, 3);
         end else begin
            hold--;
         end
         rsp_tready <= rdy;
      end
   end

   // main sequence: reset, then phases of settings with directed and random reads
   initial begin : main_seq
      int ph;
      int i;
      sb          = new();
      req_steady  = 1'b0;
      rsp_steady  = 1'b0;
      burst_left  = 0;
      base_count  = 0;
      phase_items = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_CAP_LIMIT;
      csr_wdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (ph = 0; ph < PHASES; ph++) begin
         req_steady = (ph == 1) || (ph == 4);
         rsp_steady = (ph == 1) || (ph == 3);
         if (ph != 0) apply_settings(PHASE_CAP[ph], PHASE_DIR[ph]);
         if (ph == 0) begin
            foreach (OPENING_BASES[n])
               send_base(OPENING_BASES[n][7:0], OPENING_BASES[n][14:8],
                         OPENING_BASES[n][22:15], OPENING_BASES[n][23]);
            // full-weight errors over a split run: lowest quality, then a short tail run
            for (i = 0; i < LONG_RUN_LEN; i++)
               send_base(8'h47, 7'd0, 8'hff, i == LONG_RUN_LEN - 1);
         end
         if (ph == 3) begin
            foreach (HIGH_CAP_BASES[n])
               send_base(HIGH_CAP_BASES[n][7:0], HIGH_CAP_BASES[n][14:8],
                         HIGH_CAP_BASES[n][22:15], HIGH_CAP_BASES[n][23]);
         end
         phase_items = 0;
         while (phase_items < RANDOM_PER_PHASE) send_read();
         // every read ends closed, so the block is idle once drained
         drain_results();
      end

      $display("covered %0d bases and %0d run results across %0d cap/direction settings",
               base_count, sb.result_count, PHASES);
      $display("failed checks: %0d", sb.fail_count);
      if (sb.fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #5000000;
      $display("tb NOT OK");
      $finish;
   end

endmodule

### filelist.f
rtl/core/hdiq_pkg.sv
rtl/core/hdiq_run.sv
rtl/core/hdiq_queue.sv
rtl/core/hdiq_qual.sv
rtl/core/homopolymer_directed_indel_quality_core.sv
sim/tb.sv
